@@ src/tafd_pkg.sv @@
// Package: shared types and constants for the advert filter.
`default_nettype none
package tafd_pkg;
   localparam logic [7:0] MANUF_TYPE   = 8'hFF;
   localparam logic [2:0] MIN_DATA_LEN = 3'd4;

   localparam logic [2:0] CSR_RELOG   = 3'd0;
   localparam logic [2:0] CSR_COMPANY = 3'd1;
   localparam logic [2:0] CSR_SUBTYPE = 3'd2;
   localparam logic [2:0] CSR_PLCODE  = 3'd3;
   localparam logic [2:0] CSR_MINLEN  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARSE,
      ST_SCAN,
      ST_EVICT,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic scan_start;
      logic scan_step;
      logic evict_start;
      logic evict_step;
      logic commit;
      logic emit_start;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic capture_done;
      logic scan_last;
      logic scan_hit;
      logic table_full;
      logic evict_last;
      logic emit_last;
      logic repeat_hit;
   } stat_type;
endpackage
`default_nettype wire

@@ src/tafd_ctrl.sv @@
// Controller: sequences byte parsing, table search, eviction and run output.
`default_nettype none
module tafd_ctrl
   import tafd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PARSE;
         end
         ST_PARSE: begin
            if (stat.capture_done) state_in = ST_SCAN;
            else state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_hit) state_in = ST_COMMIT;
            else if (stat.scan_last) begin
               if (stat.table_full) state_in = ST_EVICT;
               else state_in = ST_COMMIT;
            end
         end
         ST_EVICT: begin
            if (stat.evict_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // a repeat inside the interval produces no run
            if (stat.repeat_hit) state_in = ST_IDLE;
            else state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && stat.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take_byte = req_valid;
         end
         ST_PARSE: begin
            cmd.scan_start = stat.capture_done;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.evict_start = stat.scan_last && !stat.scan_hit && stat.table_full;
         end
         ST_EVICT: cmd.evict_step = 1'b1;
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_step = rsp_ready;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ src/tafd_datapath.sv @@
// Datapath: record parser, capture buffer, seen-address table and output run.
`default_nettype none
module tafd_datapath
   import tafd_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 32,
   parameter int CAPTURE_BYTES    = 31,
   parameter int MAX_ADVERT_BYTES = 62
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   input  wire logic [2:0]        csr_index,
   input  wire logic              csr_write_enable,
   input  wire logic [31:0]       csr_write_data,
   input  wire logic              req_start_of_advert,
   input  wire logic [7:0]        req_adv_byte,
   input  wire logic [5:0]        req_advert_length,
   input  wire logic [47:0]       req_device_address,
   input  wire logic signed [7:0] req_signal_strength,
   input  wire logic [1:0]        req_address_kind,
   input  wire logic [31:0]       req_time_ms,
   output logic [7:0]             rsp_payload_byte,
   output logic [4:0]             rsp_payload_index,
   output logic [4:0]             rsp_payload_length,
   output logic                   rsp_last_of_run,
   output logic [47:0]            rsp_hit_address,
   output logic signed [7:0]      rsp_hit_strength,
   output logic [1:0]             rsp_hit_address_kind,
   output logic [31:0]            rsp_detection_count
);
   localparam int PW = $clog2(MAX_ADVERT_BYTES + 1);
   localparam int CW = $clog2(CAPTURE_BYTES);
   localparam int CLW = $clog2(CAPTURE_BYTES + 1);
   localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FW = $clog2(TABLE_ENTRIES + 1);
   localparam int RW = PW + 2;

   // configuration
   logic [31:0] relog_ff;
   logic [15:0] company_ff;
   logic [7:0]  subtype_ff, plcode_ff;
   logic [5:0]  minlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relog_ff   <= 32'd300000;
         company_ff <= 16'h004C;
         subtype_ff <= 8'h12;
         plcode_ff  <= 8'h19;
         minlen_ff  <= 6'd29;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RELOG:   relog_ff   <= csr_write_data;
            CSR_COMPANY: company_ff <= csr_write_data[15:0];
            CSR_SUBTYPE: subtype_ff <= csr_write_data[7:0];
            CSR_PLCODE:  plcode_ff  <= csr_write_data[7:0];
            CSR_MINLEN:  minlen_ff  <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   // parser state; register the input transaction first
   logic [PW-1:0] pos_ff, rstart_ff;
   logic [7:0]    rlen_ff;
   logic          done_ff, cap_ff;
   logic          sv_start_ff;
   logic [7:0]    sv_byte_ff;
   logic [5:0]    sv_len_ff;
   logic [47:0]   addr_ff;
   logic [7:0]    rssi_ff;
   logic [1:0]    kind_ff;
   logic [31:0]   now_ff;
   logic [CLW-1:0] caplen_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         sv_start_ff <= req_start_of_advert;
         sv_byte_ff  <= req_adv_byte;
         sv_len_ff   <= req_advert_length;
         addr_ff     <= req_device_address;
         rssi_ff     <= req_signal_strength;
         kind_ff     <= req_address_kind;
         now_ff      <= req_time_ms;
      end
   end

   logic [PW-1:0] limit;
   logic [PW-1:0] p0, rs0;
   logic [7:0]    rl0;
   logic          dn0, ca0;
   logic [RW-1:0] offset;
   logic [9:0]    endpos;
   logic [7:0]    data_len;
   logic [CLW-1:0] cap_len;
   logic [7:0]    need;
   logic [7:0]    d;
   logic          mism;
   logic [PW-1:0] pos_in, rstart_in;
   logic [7:0]    rlen_in;
   logic          done_in, cap_in, hit_in;
   logic          wr_buf;

   always_comb begin
      limit = (RW'(sv_len_ff) > RW'(MAX_ADVERT_BYTES)) ? PW'(MAX_ADVERT_BYTES)
                                                       : PW'(sv_len_ff);
      p0  = sv_start_ff ? '0 : pos_ff;
      rs0 = sv_start_ff ? '0 : rstart_ff;
      rl0 = sv_start_ff ? '0 : rlen_ff;
      dn0 = sv_start_ff ? 1'b0 : done_ff;
      ca0 = sv_start_ff ? 1'b0 : cap_ff;
      pos_in = p0; rstart_in = rs0; rlen_in = rl0; done_in = dn0; cap_in = ca0;
      hit_in = 1'b0; wr_buf = 1'b0;
      offset = RW'(p0) - RW'(rs0);
      // wide enough that position plus a length byte never wraps
      endpos = 10'(p0) + 10'd1 + 10'(sv_byte_ff);
      data_len = rl0 - 8'd1;
      cap_len = (data_len < 8'(CAPTURE_BYTES)) ? CLW'(data_len) : CLW'(CAPTURE_BYTES);
      need = ({2'b0, minlen_ff} < 8'(MIN_DATA_LEN)) ? 8'(MIN_DATA_LEN) : {2'b0, minlen_ff};
      d = 8'(offset - RW'(2));
      mism = ((d == 8'd0) && sv_byte_ff != company_ff[7:0]) ||
             ((d == 8'd1) && sv_byte_ff != company_ff[15:8]) ||
             ((d == 8'd2) && sv_byte_ff != subtype_ff) ||
             ((d == 8'd3) && sv_byte_ff != plcode_ff);
      if (!dn0) begin
         if (p0 >= limit) begin
            done_in = 1'b1;
         end else begin
            pos_in = p0 + PW'(1);
            if (offset == '0) begin
               if (sv_byte_ff == 8'd0 || endpos > 10'(limit)) done_in = 1'b1;
               else rlen_in = sv_byte_ff;
            end else begin
               if (offset == RW'(1)) begin
                  cap_in = (sv_byte_ff == MANUF_TYPE) && (data_len >= need);
               end else if (ca0 && d < 8'(cap_len)) begin
                  wr_buf = 1'b1;
                  if (mism) cap_in = 1'b0;
                  if (!mism && d + 8'd1 == 8'(cap_len)) begin
                     cap_in = 1'b0;
                     done_in = 1'b1;
                     hit_in = 1'b1;
                  end
               end
               if (!hit_in && offset >= RW'(rl0)) begin
                  rstart_in = p0 + PW'(1);
                  cap_in = 1'b0;
               end
            end
         end
      end
   end

   logic [7:0] cbuf [CAPTURE_BYTES];

   // parse update runs in the cycle after the transaction is registered
   logic parse_ff;
   always_ff @(posedge clock) begin
      if (reset) parse_ff <= 1'b0;
      else parse_ff <= cmd.take_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; rstart_ff <= '0; rlen_ff <= '0;
         done_ff <= 1'b0; cap_ff <= 1'b0;
      end else if (parse_ff) begin
         pos_ff <= pos_in; rstart_ff <= rstart_in; rlen_ff <= rlen_in;
         done_ff <= done_in; cap_ff <= cap_in;
         caplen_ff <= cap_len;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_ff && wr_buf) cbuf[d[CW-1:0]] <= sv_byte_ff;
   end
   assign stat.capture_done = parse_ff && hit_in;

   // seen-address table
   logic [47:0]   saddr [TABLE_ENTRIES];
   logic [31:0]   stime [TABLE_ENTRIES];
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] sidx_ff;
   logic [47:0]   rd_addr_ff;
   logic [31:0]   rd_time_ff;
   logic          rd_ok_ff;
   logic [TW-1:0] best_ff, tgt_ff;
   logic [31:0]   best_time_ff;
   logic          repeat_ff;
   logic [31:0]   hits_ff;

   // read stream: issue index sidx, data back in the next cycle
   always_ff @(posedge clock) begin
      rd_addr_ff <= saddr[sidx_ff[TW-1:0]];
      rd_time_ff <= stime[sidx_ff[TW-1:0]];
      if (cmd.commit && !repeat_ff) begin
         saddr[tgt_ff] <= addr_ff;
         stime[tgt_ff] <= now_ff;
      end
   end

   logic [FW-1:0] rd_idx_ff;
   logic          scanning_ff, evicting_ff;
   logic          rd_live;
   logic          hit_now, full;

   assign full = (fill_ff == FW'(TABLE_ENTRIES));
   assign rd_live = rd_ok_ff && (scanning_ff ? (rd_idx_ff < fill_ff) : 1'b1);
   assign hit_now = scanning_ff && rd_live && (rd_addr_ff == addr_ff);
   assign stat.scan_hit = hit_now;
   assign stat.table_full = full;
   assign stat.repeat_hit = repeat_ff;
   assign stat.scan_last = scanning_ff &&
                           ((fill_ff == '0) || (rd_ok_ff && rd_idx_ff + FW'(1) >= fill_ff));
   assign stat.evict_last = evicting_ff && rd_ok_ff &&
                            (rd_idx_ff == FW'(TABLE_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0; hits_ff <= '0;
         scanning_ff <= 1'b0; evicting_ff <= 1'b0; rd_ok_ff <= 1'b0;
         sidx_ff <= '0;
      end else begin
         rd_ok_ff <= 1'b0;
         if (cmd.scan_start) begin
            scanning_ff <= 1'b1;
            sidx_ff <= FW'(1);
            rd_idx_ff <= '0;
            rd_ok_ff <= 1'b1;
            repeat_ff <= 1'b0;
            tgt_ff <= fill_ff[TW-1:0];
         end
         if (cmd.scan_step && scanning_ff) begin
            if (rd_ok_ff) rd_idx_ff <= rd_idx_ff + FW'(1);
            rd_ok_ff <= 1'b1;
            sidx_ff <= sidx_ff + FW'(1);
            if (hit_now) begin
               scanning_ff <= 1'b0;
               tgt_ff <= rd_idx_ff[TW-1:0];
               repeat_ff <= (now_ff - rd_time_ff) < relog_ff;
            end else if (stat.scan_last) begin
               scanning_ff <= 1'b0;
               tgt_ff <= fill_ff[TW-1:0];
            end
         end
         if (cmd.evict_start) begin
            // point the read stream at entry 0 for the first eviction cycle
            evicting_ff <= 1'b1;
            sidx_ff <= '0;
            rd_idx_ff <= '0;
            rd_ok_ff <= 1'b0;
            best_ff <= '0;
         end
         if (cmd.evict_step) begin
            rd_ok_ff <= 1'b1;
            if (rd_ok_ff) begin
               rd_idx_ff <= rd_idx_ff + FW'(1);
               if (rd_idx_ff == '0 || rd_time_ff < best_time_ff) begin
                  best_ff <= rd_idx_ff[TW-1:0];
                  best_time_ff <= rd_time_ff;
                  if (stat.evict_last) tgt_ff <= rd_idx_ff[TW-1:0];
               end else if (stat.evict_last) begin
                  tgt_ff <= best_ff;
               end
               if (!stat.evict_last) sidx_ff <= sidx_ff + FW'(1);
               else evicting_ff <= 1'b0;
            end else begin
               sidx_ff <= FW'(1);
            end
         end
         if (!cmd.scan_step && !cmd.evict_step && !cmd.evict_start) sidx_ff <= '0;
         if (cmd.scan_start) sidx_ff <= FW'(1);
         if (cmd.commit && !repeat_ff) begin
            hits_ff <= hits_ff + 32'd1;
            if (!full && tgt_ff == fill_ff[TW-1:0]) fill_ff <= fill_ff + FW'(1);
         end
      end
   end

   // output run
   logic [CLW-1:0] eidx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eidx_ff <= '0;
      end else begin
         if (cmd.commit) begin
            eidx_ff <= '0;
         end else if (cmd.emit_step) begin
            eidx_ff <= eidx_ff + CLW'(1);
         end
      end
   end

   assign stat.emit_last = (eidx_ff + CLW'(1) == caplen_ff);

   assign rsp_payload_byte     = cbuf[eidx_ff[CW-1:0]];
   assign rsp_payload_index    = 5'(eidx_ff);
   assign rsp_payload_length   = 5'(caplen_ff);
   assign rsp_last_of_run      = (eidx_ff + CLW'(1) == caplen_ff);
   assign rsp_hit_address      = addr_ff;
   assign rsp_hit_strength     = rssi_ff;
   assign rsp_hit_address_kind = kind_ff;
   assign rsp_detection_count  = hits_ff;
endmodule
`default_nettype wire

@@ src/tracker_advert_filter_dedup.sv @@
// Top level: advert record filter with recently-seen address dedup.
//
//   channel | direction | handshake              | moves
//   req_    | in        | req_valid / req_ready  | one advert byte per transaction
//   rsp_    | out       | rsp_valid / rsp_ready  | one captured payload byte
//   csr_    | in        | csr_write_enable       | register write, no wait
//
// Sequence: a byte that completes no capture is accepted, then parsed.
// The last byte of a matching record adds a table search over the filled
// entries until a hit, an eviction search over every entry when the table is
// full and the address is new, a commit step, then the results, each sent on
// rsp_ready; a repeat inside the interval skips the results.
// Reset is synchronous; table contents are undefined, only filled slots are read.
// A stalled rsp_ready holds the run; no new transaction is taken meanwhile.
`default_nettype none
module tracker_advert_filter_dedup
   import tafd_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 32,
   parameter int CAPTURE_BYTES    = 31,
   parameter int MAX_ADVERT_BYTES = 62
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_start_of_advert,
   input  wire logic [7:0]        req_adv_byte,
   input  wire logic [5:0]        req_advert_length,
   input  wire logic [47:0]       req_device_address,
   input  wire logic signed [7:0] req_signal_strength,
   input  wire logic [1:0]        req_address_kind,
   input  wire logic [31:0]       req_time_ms,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_payload_byte,
   output logic [4:0]             rsp_payload_index,
   output logic [4:0]             rsp_payload_length,
   output logic                   rsp_last_of_run,
   output logic [47:0]            rsp_hit_address,
   output logic signed [7:0]      rsp_hit_strength,
   output logic [1:0]             rsp_hit_address_kind,
   output logic [31:0]            rsp_detection_count
);
   cmd_type  cmd;
   stat_type stat;

   tafd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   tafd_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .CAPTURE_BYTES(CAPTURE_BYTES),
      .MAX_ADVERT_BYTES(MAX_ADVERT_BYTES)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_index(csr_index), .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_start_of_advert(req_start_of_advert), .req_adv_byte(req_adv_byte),
      .req_advert_length(req_advert_length), .req_device_address(req_device_address),
      .req_signal_strength(req_signal_strength), .req_address_kind(req_address_kind),
      .req_time_ms(req_time_ms),
      .rsp_payload_byte(rsp_payload_byte), .rsp_payload_index(rsp_payload_index),
      .rsp_payload_length(rsp_payload_length), .rsp_last_of_run(rsp_last_of_run),
      .rsp_hit_address(rsp_hit_address), .rsp_hit_strength(rsp_hit_strength),
      .rsp_hit_address_kind(rsp_hit_address_kind),
      .rsp_detection_count(rsp_detection_count)
   );
endmodule
`default_nettype wire
